>>> sv/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared constants, register map, configuration struct and log2 table entries
// for the thermistor temperature filter.
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int ADC_BITS  = 12;
    localparam int SAMPLE_W  = 12;
    localparam int TEMP_W    = 11;

    localparam int LOG_N     = 256;
    localparam int LOG_IDX_W = $clog2(LOG_N);
    localparam int LOG_W_W   = 32 - LOG_IDX_W;
    localparam int TAB_W     = 17;

    localparam int MUL_W     = 29;
    localparam int PROD_W    = 2 * MUL_W;

    localparam logic [ADC_BITS-1:0] ADC_FS = {ADC_BITS{1'b1}};
    localparam logic [31:0] OPEN_OHMS   = 32'd1000000000;
    localparam logic [24:0] T0_Q16      = 25'd19539558;
    localparam logic [23:0] K_Q16       = 24'd13543790;
    localparam logic [30:0] KELVIN_CAP  = 31'h4000_0000;
    localparam logic signed [31:0] ZERO_C_Q8 = 32'sd69926;
    localparam logic signed [31:0] STATE_MAX = 32'sd8388607;
    localparam logic signed [31:0] STATE_MIN = -32'sd8388608;
    localparam logic [16:0] OUT_HI      = 17'd560;
    localparam logic [16:0] OUT_LO_MAG  = 17'd120;
    localparam logic [16:0] WEIGHT_ONE  = 17'd65536;

    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_RFIX   = 2'd0;
    localparam logic [1:0] REG_RNOM   = 2'd1;
    localparam logic [1:0] REG_BETA   = 2'd2;
    localparam logic [1:0] REG_WEIGHT = 2'd3;

    typedef struct packed {
        logic [19:0] rfix;
        logic [19:0] rnom;
        logic [13:0] beta;
        logic [16:0] weight;
    } t_cfg;

    // log2(1 + i/LOG_N) in Q16, truncated
    function automatic logic [TAB_W-1:0] ttf_log_entry(input int unsigned i);
        longint unsigned m;
        logic [TAB_W-1:0] r;
        r = '0;
        if (i >= LOG_N) begin
            r = TAB_W'(65536);
        end else begin
            m = (64'd1 << 30) + ((64'(i) << 30) / LOG_N);
            for (int b = 15; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    r[b] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> sv/ttf_sample_if.sv
// ----------------------------------------------------------------------------
// ttf_sample_if
// Valid/ready channel carrying one converter sample item.
// ----------------------------------------------------------------------------
interface ttf_sample_if;
    logic                          valid;
    logic                          ready;
    logic [ttf_pkg::SAMPLE_W-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> sv/ttf_result_if.sv
// ----------------------------------------------------------------------------
// ttf_result_if
// Valid/ready channel carrying one filtered temperature item.
// ----------------------------------------------------------------------------
interface ttf_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [ttf_pkg::TEMP_W-1:0]  temperature_c;

    modport source (output valid, output temperature_c, input ready);
    modport sink   (input valid, input temperature_c, output ready);
endinterface

>>> sv/thermistor_temperature_filter.sv
// ----------------------------------------------------------------------------
// thermistor_temperature_filter
// NTC divider sample to filtered whole degrees Celsius via beta equation.
// ----------------------------------------------------------------------------
// Each sample item runs through a sequence of states after it is accepted:
// PREP forms the divider resistance; each of the three log2 evaluations runs
// through NORM, which shifts the operand left by eight bits or by one until
// its top bit is set (up to ten shifts), then TAB and LMUL; KMUL, BMUL, DSUM
// and DCHK form the denominator; the kelvin quotient runs on a restoring
// divider, one bit per cycle, unless it is capped; CELS converts to Celsius;
// once the filter is seeded, MIX1, MIX2 and RND form the blend; and OUT loads
// the result. The sample input is ready only between items; a finished result
// sits in an output register, so the next sample is taken while it waits, and
// a new result holds in its last state until that register is free.
module thermistor_temperature_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ttf_sample_if.sink                  i_sample,
    ttf_result_if.source                o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttf_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ttf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_TAB  = 4'd3;
    localparam logic [3:0] S_LMUL = 4'd4;
    localparam logic [3:0] S_KMUL = 4'd5;
    localparam logic [3:0] S_BMUL = 4'd6;
    localparam logic [3:0] S_DSUM = 4'd7;
    localparam logic [3:0] S_DCHK = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_CELS = 4'd10;
    localparam logic [3:0] S_MIX1 = 4'd11;
    localparam logic [3:0] S_MIX2 = 4'd12;
    localparam logic [3:0] S_RND  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    t_cfg w_cfg;

    ttf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [3:0]                r_state, n_state;
    logic [ADC_BITS-1:0]       r_a, n_a;
    logic [31:0]               r_x, n_x;
    logic [4:0]                r_p, n_p;
    logic [1:0]                r_lsel, n_lsel;
    logic [TAB_W-1:0]          r_lo, n_lo;
    logic [TAB_W-1:0]          r_diff, n_diff;
    logic signed [23:0]        r_l2, n_l2;
    logic signed [47:0]        r_kl, n_kl;
    logic [38:0]               r_bt, n_bt;
    logic signed [48:0]        r_d, n_d;
    logic [47:0]               r_rem, n_rem;
    logic [30:0]               r_nsh, n_nsh;
    logic [30:0]               r_q, n_q;
    logic [4:0]                r_cnt, n_cnt;
    logic [30:0]               r_tk, n_tk;
    logic signed [23:0]        r_t, n_t;
    logic signed [41:0]        r_mix, n_mix;
    logic signed [23:0]        r_filt, n_filt;
    logic                      r_seeded, n_seeded;
    logic                      r_out_valid, n_out_valid;
    logic signed [TEMP_W-1:0]  r_out, n_out;

    logic [TAB_W-1:0]          w_tab [LOG_N+1];
    logic [19:0]               w_rf, w_r0;
    logic [13:0]               w_beta;
    logic [16:0]               w_wq, w_wold;
    logic [11:0]               w_den;
    logic [LOG_IDX_W-1:0]      w_idx;
    logic [LOG_IDX_W:0]        w_idx1;
    logic [LOG_W_W-1:0]        w_wlow;
    logic signed [MUL_W-1:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic [21:0]               w_logv;
    logic [48:0]               w_tr, w_dd;
    logic                      w_ge;
    logic signed [31:0]        w_t32;
    logic                      w_mneg;
    logic [41:0]               w_mmag;
    logic [41:0]               w_mrs;
    logic                      w_fneg;
    logic [23:0]               w_fmag;
    logic [24:0]               w_fsum;
    logic [16:0]               w_vr;

    for (genvar g = 0; g <= LOG_N; g++) begin : g_tab
        assign w_tab[g] = ttf_log_entry(g);
    end

    assign w_rf   = (w_cfg.rfix == '0) ? 20'd1 : w_cfg.rfix;
    assign w_r0   = (w_cfg.rnom == '0) ? 20'd1 : w_cfg.rnom;
    assign w_beta = (w_cfg.beta == '0) ? 14'd1 : w_cfg.beta;
    assign w_wq   = (w_cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : w_cfg.weight;
    assign w_wold = WEIGHT_ONE - w_wq;
    assign w_den  = (r_a == '0 || r_a == ADC_FS) ? 12'd1 : 12'(ADC_FS - r_a);

    assign w_idx  = r_x[30 -: LOG_IDX_W];
    assign w_idx1 = {1'b0, w_idx} + 1'b1;
    assign w_wlow = {r_x[30-LOG_IDX_W:0], 1'b0};

    always_comb begin
        unique case (r_state)
            S_PREP: begin
                w_ma = $signed(MUL_W'(w_rf));
                w_mb = $signed(MUL_W'(r_a));
            end
            S_LMUL: begin
                w_ma = $signed(MUL_W'(r_diff));
                w_mb = $signed(MUL_W'(w_wlow));
            end
            S_KMUL: begin
                w_ma = $signed(MUL_W'(K_Q16));
                w_mb = $signed({{(MUL_W-24){r_l2[23]}}, r_l2});
            end
            S_BMUL: begin
                w_ma = $signed(MUL_W'(w_beta));
                w_mb = $signed(MUL_W'(T0_Q16));
            end
            S_MIX1: begin
                w_ma = $signed({{(MUL_W-24){r_filt[23]}}, r_filt});
                w_mb = $signed(MUL_W'(w_wold));
            end
            S_MIX2: begin
                w_ma = $signed({{(MUL_W-24){r_t[23]}}, r_t});
                w_mb = $signed(MUL_W'(w_wq));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_logv = 22'({r_p, 16'd0}) + 22'(r_lo) + 22'(w_prod[LOG_W_W +: TAB_W]);

    assign w_tr = {r_rem, r_nsh[30]};
    assign w_dd = {1'b0, r_d[47:0]};
    assign w_ge = (w_tr >= w_dd);

    assign w_t32 = $signed({1'b0, r_tk}) - ZERO_C_Q8;

    assign w_mneg = r_mix[41];
    assign w_mmag = w_mneg ? 42'(-r_mix) : 42'(r_mix);
    assign w_mrs  = (w_mmag + 42'd32768) >> 16;

    assign w_fneg = r_filt[23];
    assign w_fmag = w_fneg ? 24'(-r_filt) : 24'(r_filt);
    assign w_fsum = {1'b0, w_fmag} + 25'd128;
    assign w_vr   = w_fsum[24:8];

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_x         = r_x;
        n_p         = r_p;
        n_lsel      = r_lsel;
        n_lo        = r_lo;
        n_diff      = r_diff;
        n_l2        = r_l2;
        n_kl        = r_kl;
        n_bt        = r_bt;
        n_d         = r_d;
        n_rem       = r_rem;
        n_nsh       = r_nsh;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_tk        = r_tk;
        n_t         = r_t;
        n_mix       = r_mix;
        n_filt      = r_filt;
        n_seeded    = r_seeded;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    n_a     = i_sample.adc_sample[ADC_BITS-1:0];
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_a == '0) begin
                    n_x = OPEN_OHMS;
                end else if (r_a == ADC_FS) begin
                    n_x = 32'd1;
                end else begin
                    n_x = w_prod[31:0];
                end
                n_p     = 5'd31;
                n_lsel  = 2'd0;
                n_state = S_NORM;
            end
            S_NORM: begin
                priority if (r_x[31]) begin
                    n_state = S_TAB;
                end else if (r_x[31:24] == 8'd0) begin
                    n_x = r_x << 8;
                    n_p = r_p - 5'd8;
                end else begin
                    n_x = r_x << 1;
                    n_p = r_p - 5'd1;
                end
            end
            S_TAB: begin
                n_lo    = w_tab[w_idx];
                n_diff  = w_tab[w_idx1] - w_tab[w_idx];
                n_state = S_LMUL;
            end
            S_LMUL: begin
                n_p = 5'd31;
                unique case (r_lsel)
                    2'd0: begin
                        n_l2    = $signed({2'b00, w_logv});
                        n_x     = 32'(w_den);
                        n_lsel  = 2'd1;
                        n_state = S_NORM;
                    end
                    2'd1: begin
                        n_l2    = r_l2 - $signed({2'b00, w_logv});
                        n_x     = 32'(w_r0);
                        n_lsel  = 2'd2;
                        n_state = S_NORM;
                    end
                    default: begin
                        n_l2    = r_l2 - $signed({2'b00, w_logv});
                        n_state = S_KMUL;
                    end
                endcase
            end
            S_KMUL: begin
                n_kl    = w_prod[47:0];
                n_state = S_BMUL;
            end
            S_BMUL: begin
                n_bt    = w_prod[38:0];
                n_state = S_DSUM;
            end
            S_DSUM: begin
                n_d     = $signed({3'b000, w_beta, 32'd0}) + $signed({r_kl[47], r_kl});
                n_state = S_DCHK;
            end
            S_DCHK: begin
                priority if (r_d[48] || r_d == '0) begin
                    n_tk    = KELVIN_CAP;
                    n_state = S_CELS;
                end else if ({16'd0, r_bt, 24'd0} >= {r_d[47:0], 31'd0}) begin
                    n_tk    = KELVIN_CAP;
                    n_state = S_CELS;
                end else begin
                    n_rem   = {16'd0, r_bt[38:7]};
                    n_nsh   = {r_bt[6:0], 24'd0};
                    n_q     = '0;
                    n_cnt   = 5'd30;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? 48'(w_tr - w_dd) : w_tr[47:0];
                n_q   = {r_q[29:0], w_ge};
                n_nsh = r_nsh << 1;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_tk    = (n_q > KELVIN_CAP) ? KELVIN_CAP : n_q;
                    n_state = S_CELS;
                end
            end
            S_CELS: begin
                priority if (w_t32 > STATE_MAX) begin
                    n_t = STATE_MAX[23:0];
                end else if (w_t32 < STATE_MIN) begin
                    n_t = STATE_MIN[23:0];
                end else begin
                    n_t = w_t32[23:0];
                end
                if (r_seeded) begin
                    n_state = S_MIX1;
                end else begin
                    n_filt   = n_t;
                    n_seeded = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_MIX1: begin
                n_mix   = w_prod[41:0];
                n_state = S_MIX2;
            end
            S_MIX2: begin
                n_mix   = r_mix + w_prod[41:0];
                n_state = S_RND;
            end
            S_RND: begin
                n_filt  = w_mneg ? 24'(-w_mrs) : w_mrs[23:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    if (w_fneg) begin
                        n_out = (w_vr > OUT_LO_MAG) ? -TEMP_W'(OUT_LO_MAG) : -TEMP_W'(w_vr);
                    end else begin
                        n_out = (w_vr > OUT_HI) ? TEMP_W'(OUT_HI) : TEMP_W'(w_vr);
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_filt      <= '0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
            r_filt      <= n_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_x    <= n_x;
        r_p    <= n_p;
        r_lsel <= n_lsel;
        r_lo   <= n_lo;
        r_diff <= n_diff;
        r_l2   <= n_l2;
        r_kl   <= n_kl;
        r_bt   <= n_bt;
        r_d    <= n_d;
        r_rem  <= n_rem;
        r_nsh  <= n_nsh;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_tk   <= n_tk;
        r_t    <= n_t;
        r_mix  <= n_mix;
        r_out  <= n_out;
    end

    assign i_sample.ready         = (r_state == S_IDLE);
    assign o_result.valid         = r_out_valid;
    assign o_result.temperature_c = r_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> (r_state == S_PREP))
        else $error("accepted item did not start the sequence");

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_x != '0))
        else $error("log operand is zero");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_d[47:0]))
        else $error("divider remainder not below divisor");

    a_seed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_seeded) |-> r_seeded)
        else $error("filter seed flag dropped");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_result.ready) |=> (r_state == S_OUT))
        else $error("result overwrote a pending item");

endmodule

>>> sv/ttf_cfg.sv
// ----------------------------------------------------------------------------
// ttf_cfg
// APB register file: divider resistor, nominal resistance, beta and weight.
// ----------------------------------------------------------------------------
module ttf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttf_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ttf_pkg::t_cfg               o_cfg
);
    import ttf_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rfix   <= 20'd10000;
            r_cfg.rnom   <= 20'd4700;
            r_cfg.beta   <= 14'd3950;
            r_cfg.weight <= 17'd9830;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_RFIX:   r_cfg.rfix   <= pwdata[19:0];
                REG_RNOM:   r_cfg.rnom   <= pwdata[19:0];
                REG_BETA:   r_cfg.beta   <= pwdata[13:0];
                REG_WEIGHT: r_cfg.weight <= pwdata[16:0];
                default:    r_cfg.rfix   <= r_cfg.rfix;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RFIX:   prdata = {12'd0, r_cfg.rfix};
            REG_RNOM:   prdata = {12'd0, r_cfg.rnom};
            REG_BETA:   prdata = {18'd0, r_cfg.beta};
            REG_WEIGHT: prdata = {15'd0, r_cfg.weight};
            default:    prdata = '0;
        endcase
    end

endmodule

>>> test/thermistor_temperature_filter_tb.sv
// ----------------------------------------------------------------------------
// thermistor_temperature_filter_tb
// Drives converter samples and register writes into the filter and checks
// every temperature item against a fixed value or a bit-true fixed-point
// prediction of the divider, log2, beta equation and IIR blend, with random
// idling on both channels and several register settings, extremes among them.
// ----------------------------------------------------------------------------
module thermistor_temperature_filter_tb;
    import ttf_pkg::*;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        int unsigned value;
        logic [11:0] sample;
        bit          has_exp;
        int          exp_temp;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ttf_sample_if sample_ch ();
    ttf_result_if result_ch ();

    thermistor_temperature_filter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_result (result_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bit          failed;
    logic signed [TEMP_W-1:0] temps_due[$];
    longint unsigned log_frac[0:256];
    logic [19:0] rfix_q;
    logic [19:0] rnom_q;
    logic [13:0] beta_q;
    logic [16:0] weight_q;
    longint      filt_q8;
    bit          seeded;

    t_stim_row directed_rows[] = '{
        '{0, REG_RFIX,   0,       12'd2048, 0, 0},
        '{1, REG_WEIGHT, 131071,  12'd0,    0, 0},
        '{1, REG_BETA,   1000,    12'd0,    0, 0},
        '{1, REG_RNOM,   1000000, 12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd4095, 1, 560},
        '{0, REG_RFIX,   0,       12'd2048, 0, 0},
        '{1, REG_RNOM,   0,       12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd0,    1, -120},
        '{0, REG_RFIX,   0,       12'd1,    0, 0},
        '{0, REG_RFIX,   0,       12'd4094, 0, 0},
        '{1, REG_BETA,   0,       12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd2048, 0, 0},
        '{0, REG_RFIX,   0,       12'd0,    0, 0},
        '{1, REG_RFIX,   0,       12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd100,  0, 0},
        '{1, REG_RFIX,   1000000, 12'd0,    0, 0},
        '{1, REG_RNOM,   1,       12'd0,    0, 0},
        '{1, REG_BETA,   16383,   12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd4000, 0, 0},
        '{0, REG_RFIX,   0,       12'd0,    0, 0},
        '{1, REG_WEIGHT, 0,       12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd4095, 0, 0},
        '{0, REG_RFIX,   0,       12'd2731, 0, 0},
        '{1, REG_WEIGHT, 65536,   12'd0,    0, 0},
        '{0, REG_RFIX,   0,       12'd1365, 0, 0}
    };

    always #4 i_clk = ~i_clk;

    function automatic longint log2_q16(longint unsigned x);
        int unsigned p;
        longint unsigned m, frac, scaled, idx, w, lo, hi;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0) p++;
        m = (p >= 32) ? (x >> (p - 32)) : (x << (32 - p));
        frac = m - (64'd1 << 32);
        scaled = frac * 256;
        idx = scaled >> 32;
        if (idx >= 256) idx = 255;
        w = scaled & 64'hFFFF_FFFF;
        lo = log_frac[idx];
        hi = log_frac[idx + 1];
        return longint'((64'(p) << 16) + lo + (((hi - lo) * w) >> 32));
    endfunction

    function automatic longint round_half_away(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic signed [TEMP_W-1:0] predict_temperature(logic [11:0] smp);
        longint unsigned a, rf, r0, bk, num, den, tk;
        longint w, l2, d, t, v;
        a  = smp;
        rf = (rfix_q == 0) ? 1 : rfix_q;
        r0 = (rnom_q == 0) ? 1 : rnom_q;
        bk = (beta_q == 0) ? 1 : beta_q;
        w  = (weight_q > WEIGHT_ONE) ? 65536 : longint'(weight_q);
        if (a == 0) begin
            num = OPEN_OHMS;
            den = 1;
        end else if (a >= ADC_FS) begin
            num = 1;
            den = 1;
        end else begin
            num = rf * a;
            den = ADC_FS - a;
        end
        l2 = log2_q16(num) - log2_q16(den) - log2_q16(r0);
        d = longint'(bk << 32) + longint'(K_Q16) * l2;
        if (d <= 0) begin
            tk = KELVIN_CAP;
        end else begin
            tk = ((bk * longint'(T0_Q16)) << 24) / longint'(d);
            if (tk > KELVIN_CAP) tk = KELVIN_CAP;
        end
        t = longint'(tk) - longint'(ZERO_C_Q8);
        if (t > STATE_MAX) t = STATE_MAX;
        if (t < STATE_MIN) t = STATE_MIN;
        if (!seeded) begin
            filt_q8 = t;
            seeded = 1;
        end else begin
            filt_q8 = round_half_away(filt_q8 * (65536 - w) + t * w, 16);
        end
        v = round_half_away(filt_q8, 8);
        if (v > 560) v = 560;
        if (v < -120) v = -120;
        return v[TEMP_W-1:0];
    endfunction

    task automatic write_register(logic [1:0] idx, int unsigned value);
        sample_ch.valid <= 1'b0;
        while (temps_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RFIX:   rfix_q   = value[19:0];
            REG_RNOM:   rnom_q   = value[19:0];
            REG_BETA:   beta_q   = value[13:0];
            REG_WEIGHT: weight_q = value[16:0];
        endcase
    endtask

    task automatic send_sample(logic [11:0] smp, bit has_exp, int exp_temp, bit quiet);
        int gap;
        logic signed [TEMP_W-1:0] guess;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= smp;
        do @(posedge i_clk); while (!sample_ch.ready);
        guess = predict_temperature(smp);
        temps_due.push_back(has_exp ? exp_temp[TEMP_W-1:0] : guess);
    endtask

    function automatic int unsigned pick_ohms();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 1000000;
            2: return 0;
            3: return $urandom_range(1000, 100000);
            default: return $urandom_range(1, 1000000);
        endcase
    endfunction

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return ADC_FS;
            2: return 12'($urandom_range(1, 8));
            3: return 12'($urandom_range(4087, 4094));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready = 1'b0;
        failed = 0;
        for (int i = 0; i < 256; i++) begin
            longint unsigned m;
            longint unsigned r;
            m = (64'd1 << 30) + ((64'(i) << 30) / 256);
            r = 0;
            for (int b = 15; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    r = r | (64'd1 << b);
                end
            end
            log_frac[i] = r;
        end
        log_frac[256] = 65536;
        rfix_q = 20'd10000;
        rnom_q = 20'd4700;
        beta_q = 14'd3950;
        weight_q = 17'd9830;
        filt_q8 = 0;
        seeded = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_register(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_sample(directed_rows[i].sample, directed_rows[i].has_exp,
                            directed_rows[i].exp_temp, 0);
        end

        for (int ph = 0; ph < 8; ph++) begin
            bit quiet;
            write_register(REG_RFIX, (ph == 0) ? 10000 : pick_ohms());
            write_register(REG_RNOM, (ph == 0) ? 4700 : pick_ohms());
            case ($urandom_range(0, 3))
                0: write_register(REG_BETA, 1000);
                1: write_register(REG_BETA, 10000);
                2: write_register(REG_BETA, $urandom_range(0, 16383));
                default: write_register(REG_BETA, $urandom_range(1000, 10000));
            endcase
            case ($urandom_range(0, 4))
                0: write_register(REG_WEIGHT, 0);
                1: write_register(REG_WEIGHT, 65536);
                2: write_register(REG_WEIGHT, $urandom_range(65537, 131071));
                default: write_register(REG_WEIGHT, $urandom_range(0, 65536));
            endcase
            quiet = 0;
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 15) == 0) quiet = !quiet;
                send_sample(pick_sample(), 0, 0, quiet);
            end
        end
        sample_ch.valid <= 1'b0;
        while (temps_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        bit quiet;
        int stall;
        logic signed [TEMP_W-1:0] want;
        quiet = 0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            if (temps_due.size() == 0) begin
                $error("temperature_c: no item expected, actual %0d",
                       result_ch.temperature_c);
                failed = 1;
            end else begin
                want = temps_due.pop_front();
                if (result_ch.temperature_c !== want) begin
                    $error("temperature_c: expected %0d, actual %0d",
                           want, result_ch.temperature_c);
                    failed = 1;
                end
            end
        end
    end

    initial begin
        #10000000;
        $display("FAIL");
        $finish;
    end

endmodule
